// File: hw/rtl/vmalu_pkg.sv
package vmalu_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned CountWidth = 5;
   localparam logic [1:0] FlagZero = 2'b01;
   localparam logic [1:0] FlagNeg = 2'b10;
   localparam int unsigned HalfShift = 16;

   typedef enum logic [4:0] {
      OP_JMP  = 5'd1,
      OP_JZ   = 5'd2,
      OP_JP   = 5'd3,
      OP_JN   = 5'd4,
      OP_JNZ  = 5'd5,
      OP_JNP  = 5'd6,
      OP_JNN  = 5'd7,
      OP_NOT  = 5'd8,
      OP_MOV  = 5'd16,
      OP_ADD  = 5'd17,
      OP_SUB  = 5'd18,
      OP_MUL  = 5'd19,
      OP_DIV  = 5'd20,
      OP_CMP  = 5'd21,
      OP_SHL  = 5'd22,
      OP_SHR  = 5'd23,
      OP_SAR  = 5'd24,
      OP_AND  = 5'd25,
      OP_OR   = 5'd26,
      OP_XOR  = 5'd27,
      OP_SWAP = 5'd28,
      OP_LDL  = 5'd29,
      OP_LDH  = 5'd30
   } opcode_type;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusDivZero = 2'd1;
   localparam logic [1:0] StatusNotHandled = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture operands, do the simple ops
      logic div_start; // set up divider
      logic div_step;  // one quotient bit
      logic div_fix;   // sign fix and commit
      logic mul_fin;   // commit product
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_div;
      logic is_mul;
      logic div_last;
   } dp_stat_type;

endpackage

// File: hw/rtl/vm_alu_condition_branch_top.sv
// Sequence: most opcodes go from the request straight to the output register; MUL
// passes a product commit state, DIV 32 quotient bits from the restoring divider
// loop and then a sign fix; the result then waits in the output register until taken.
// Throughput: one word at a time; the next request is taken the cycle after the
// result leaves.
// Reset (synchronous): condition code, remainder register and outputs clear to zero.
module vm_alu_condition_branch_top
   import vmalu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [4:0] req_func,
   input  logic signed [31:0] req_a_value,
   input  logic signed [31:0] req_b_value,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_write_dest,
   output logic signed [31:0] rsp_dest_value,
   output logic rsp_write_source,
   output logic signed [31:0] rsp_source_value,
   output logic [1:0] rsp_flags_out,
   output logic signed [31:0] rsp_remainder_out,
   output logic rsp_branch_taken,
   output logic [1:0] rsp_status
);

   // command and status between sequencer and datapath
   dp_cmd_type cmd;
   dp_stat_type stat;

   vmalu_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   vmalu_datapath u_dp (
      .clock, .reset, .cmd, .stat, .req_func, .req_a_value, .req_b_value,
      .rsp_write_dest, .rsp_dest_value, .rsp_write_source, .rsp_source_value,
      .rsp_flags_out, .rsp_remainder_out, .rsp_branch_taken, .rsp_status
   );

endmodule

// File: hw/rtl/vmalu_datapath.sv
module vmalu_datapath
   import vmalu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  dp_cmd_type cmd,
   output dp_stat_type stat,
   input  logic [4:0] req_func,
   input  logic signed [31:0] req_a_value,
   input  logic signed [31:0] req_b_value,
   output logic rsp_write_dest,
   output logic signed [31:0] rsp_dest_value,
   output logic rsp_write_source,
   output logic signed [31:0] rsp_source_value,
   output logic [1:0] rsp_flags_out,
   output logic signed [31:0] rsp_remainder_out,
   output logic rsp_branch_taken,
   output logic [1:0] rsp_status
);

   logic [1:0] flags_ff, flags_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff, d_in, prod_ff;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic na_ff, nb_ff;
   logic wd_ff, wd_in, ws_ff, ws_in, br_ff, br_in;
   logic [31:0] dv_ff, dv_in, sv_ff, sv_in;
   logic [1:0] st_ff, st_in;

   logic [31:0] a, b, res, shl_v, shr_v, sar_v;
   logic setcc, big;
   logic [32:0] trial;
   logic [31:0] rsh;

   function automatic logic [1:0] flags_of(input logic [31:0] v);
      if (v == '0) return FlagZero;
      if (v[31]) return FlagNeg;
      return 2'b00;
   endfunction

   assign a = req_a_value;
   assign b = req_b_value;
   assign big = |b[31:5];
   assign shl_v = big ? '0 : a << b[4:0];
   assign shr_v = big ? '0 : a >> b[4:0];
   assign sar_v = big ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
   assign stat.is_div = (req_func == OP_DIV) && (b != '0);
   assign stat.is_mul = (req_func == OP_MUL);
   assign stat.div_last = (cnt_ff == '0);

   // restoring divider step on magnitudes
   assign rsh = {r_ff[30:0], q_ff[31]};
   assign trial = {1'b0, rsh} - {1'b0, d_ff};

   always_comb begin
      flags_in = flags_ff;
      rem_in = rem_ff;
      wd_in = wd_ff; ws_in = ws_ff; br_in = br_ff;
      dv_in = dv_ff; sv_in = sv_ff; st_in = st_ff;
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      res = '0;
      setcc = 1'b0;
      if (cmd.load) begin
         wd_in = 1'b0; ws_in = 1'b0; br_in = 1'b0; sv_in = '0; st_in = StatusOk;
         case (req_func)
            OP_JMP:  br_in = 1'b1;
            OP_JZ:   br_in = flags_ff[0];
            OP_JP:   br_in = (flags_ff == 2'b00);
            OP_JN:   br_in = (flags_ff == FlagNeg);
            OP_JNZ:  br_in = (flags_ff != FlagZero);
            OP_JNP:  br_in = (flags_ff != 2'b00);
            OP_JNN:  br_in = (flags_ff != FlagNeg);
            OP_NOT:  begin wd_in = 1'b1; res = ~a; setcc = 1'b1; end
            OP_MOV:  begin wd_in = 1'b1; res = b; end
            OP_ADD:  begin wd_in = 1'b1; res = a + b; setcc = 1'b1; end
            OP_SUB:  begin wd_in = 1'b1; res = a - b; setcc = 1'b1; end
            OP_MUL:  wd_in = 1'b1;
            OP_DIV:  begin
               if (b == '0) st_in = StatusDivZero;
               else wd_in = 1'b1;
            end
            OP_CMP:  begin res = a - b; setcc = 1'b1; end
            OP_SHL:  begin wd_in = 1'b1; res = shl_v; end
            OP_SHR:  begin wd_in = 1'b1; res = shr_v; end
            OP_SAR:  begin wd_in = 1'b1; res = sar_v; end
            OP_AND:  begin wd_in = 1'b1; res = a & b; end
            OP_OR:   begin wd_in = 1'b1; res = a | b; end
            OP_XOR:  begin wd_in = 1'b1; res = a ^ b; end
            OP_SWAP: begin wd_in = 1'b1; res = b; ws_in = 1'b1; sv_in = a; end
            OP_LDL:  begin wd_in = 1'b1; res = {a[31:16], b[15:0]}; end
            OP_LDH:  begin
               wd_in = 1'b1; res = {b[15:0], a[15:0]};
            end
            default: st_in = StatusNotHandled;
         endcase
         if (setcc) flags_in = flags_of(res);
         dv_in = (req_func == OP_CMP) ? '0 : res;
      end
      if (cmd.div_start) begin
         q_in = a[31] ? 32'(0 - a) : a;
         d_in = b[31] ? 32'(0 - b) : b;
         r_in = '0;
         cnt_in = '1;
      end
      if (cmd.div_step) begin
         if (!trial[32]) r_in = trial[31:0];
         else r_in = rsh;
         q_in = {q_ff[30:0], ~trial[32]};
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.div_fix) begin
         dv_in = (na_ff != nb_ff) ? 32'(0 - q_ff) : q_ff;
         rem_in = na_ff ? 32'(0 - r_ff) : r_ff;
         flags_in = flags_of(dv_in);
      end
      if (cmd.mul_fin) begin
         dv_in = prod_ff;
         flags_in = flags_of(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         rem_ff <= '0;
         wd_ff <= 1'b0; ws_ff <= 1'b0; br_ff <= 1'b0;
         dv_ff <= '0; sv_ff <= '0; st_ff <= StatusOk;
      end else begin
         flags_ff <= flags_in;
         rem_ff <= rem_in;
         wd_ff <= wd_in; ws_ff <= ws_in; br_ff <= br_in;
         dv_ff <= dv_in; sv_ff <= sv_in; st_ff <= st_in;
      end
      if (cmd.load) begin
         na_ff <= a[31]; nb_ff <= b[31];
         prod_ff <= a * b;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
   end

   assign rsp_write_dest = wd_ff;
   assign rsp_dest_value = dv_ff;
   assign rsp_write_source = ws_ff;
   assign rsp_source_value = sv_ff;
   assign rsp_flags_out = flags_ff;
   assign rsp_remainder_out = rem_ff;
   assign rsp_branch_taken = br_ff;
   assign rsp_status = st_ff;

`ifndef SYNTH
   a_swap_src: assert property (@(posedge clock) disable iff (reset)
      rsp_write_source |-> rsp_write_dest) else $error("source write without dest");
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.div_fix |=> (rsp_flags_out != 2'b11)) else $error("bad flags after div");
   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      (rsp_status != StatusOk) |-> !rsp_write_dest) else $error("write on error");
`endif

endmodule

// File: hw/rtl/vmalu_ctrl.sv
module vmalu_ctrl
   import vmalu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DIV  = 5'b00010,
      S_FIX  = 5'b00100,
      S_MUL  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            cmd.load = 1'b1;
            cmd.div_start = stat.is_div;
            if (stat.is_div) state_in = S_DIV;
            else if (stat.is_mul) state_in = S_MUL;
            else state_in = S_OUT;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_FIX;
         end
         S_FIX: begin cmd.div_fix = 1'b1; state_in = S_OUT; end
         S_MUL: begin cmd.mul_fin = 1'b1; state_in = S_OUT; end
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready during result");
   a_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_step, cmd.div_fix, cmd.mul_fin}))
      else $error("overlapping commands");
`endif

endmodule

// File: dv/vm_alu_condition_branch_checker.sv
module vm_alu_condition_branch_checker
   import vmalu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic [4:0] req_func,
   input  logic signed [31:0] req_a_value,
   input  logic signed [31:0] req_b_value,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic rsp_write_dest,
   input  logic signed [31:0] rsp_dest_value,
   input  logic rsp_write_source,
   input  logic signed [31:0] rsp_source_value,
   input  logic [1:0] rsp_flags_out,
   input  logic signed [31:0] rsp_remainder_out,
   input  logic rsp_branch_taken,
   input  logic [1:0] rsp_status,
   output int unsigned fail_count,
   output int unsigned pending_count,
   output int unsigned word_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic wd;
      logic [31:0] dv;
      logic ws;
      logic [31:0] sv;
      logic [1:0] fl;
      logic [31:0] rem;
      logic br;
      logic [1:0] st;
   } exec_word_type;

   exec_word_type exec_queue[$];
   logic [1:0] model_flags;
   logic [31:0] model_rem;

   function automatic logic [1:0] flags_for(logic [31:0] v);
      if (v == '0) return FlagZero;
      if (v[31]) return FlagNeg;
      return 2'b00;
   endfunction

   // Advance the model state by one word and return the expected result.
   function automatic exec_word_type execute(logic [4:0] f, logic [31:0] a, logic [31:0] b);
      exec_word_type r;
      logic setcc;
      logic [31:0] ma, mb, q, rm;
      r = '0;
      setcc = 1'b0;
      case (f)
         OP_JMP: r.br = 1'b1;
         OP_JZ:  r.br = model_flags[0];
         OP_JP:  r.br = (model_flags == 2'b00);
         OP_JN:  r.br = (model_flags == FlagNeg);
         OP_JNZ: r.br = (model_flags != FlagZero);
         OP_JNP: r.br = (model_flags != 2'b00);
         OP_JNN: r.br = (model_flags != FlagNeg);
         OP_NOT: begin r.wd = 1; r.dv = ~a; setcc = 1; end
         OP_MOV: begin r.wd = 1; r.dv = b; end
         OP_ADD: begin r.wd = 1; r.dv = a + b; setcc = 1; end
         OP_SUB: begin r.wd = 1; r.dv = a - b; setcc = 1; end
         OP_MUL: begin r.wd = 1; r.dv = a * b; setcc = 1; end
         OP_DIV: begin
            if (b == '0) begin
               r.st = StatusDivZero;
            end else begin
               ma = a[31] ? -a : a;
               mb = b[31] ? -b : b;
               q = ma / mb;
               rm = ma % mb;
               if (a[31] != b[31]) q = -q;
               if (a[31]) rm = -rm;
               r.wd = 1; r.dv = q; model_rem = rm; setcc = 1;
            end
         end
         OP_CMP: begin r.dv = a - b; setcc = 1; end
         OP_SHL: begin r.wd = 1; r.dv = (b >= 32) ? '0 : a << b[4:0]; end
         OP_SHR: begin r.wd = 1; r.dv = (b >= 32) ? '0 : a >> b[4:0]; end
         OP_SAR: begin
            r.wd = 1;
            r.dv = (b >= 32) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
         end
         OP_AND: begin r.wd = 1; r.dv = a & b; end
         OP_OR:  begin r.wd = 1; r.dv = a | b; end
         OP_XOR: begin r.wd = 1; r.dv = a ^ b; end
         OP_SWAP: begin r.wd = 1; r.dv = b; r.ws = 1; r.sv = a; end
         OP_LDL: begin r.wd = 1; r.dv = {a[31:16], b[15:0]}; end
         OP_LDH: begin r.wd = 1; r.dv = {b[15:0], a[15:0]}; end
         default: r.st = StatusNotHandled;
      endcase
      if (setcc) model_flags = flags_for(r.dv);
      if (f == OP_CMP) r.dv = '0;
      r.fl = model_flags;
      r.rem = model_rem;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      exec_word_type e;
      if (reset) begin
         model_flags = 2'b00;
         model_rem = '0;
         exec_queue.delete();
         fail_count <= 0;
         word_count <= 0;
      end else begin
         if (req_valid && req_ready)
            exec_queue.push_back(execute(req_func, req_a_value, req_b_value));
         if (rsp_valid && rsp_ready) begin
            word_count <= word_count + 1;
            if (exec_queue.size() == 0) begin
               report_mismatch("unexpected word", '0, '0);
            end else begin
               e = exec_queue.pop_front();
               if (rsp_write_dest !== e.wd) report_mismatch("write_dest", rsp_write_dest, e.wd);
               if (rsp_dest_value !== e.dv) report_mismatch("dest_value", rsp_dest_value, e.dv);
               if (rsp_write_source !== e.ws)
                  report_mismatch("write_source", rsp_write_source, e.ws);
               if (rsp_source_value !== e.sv)
                  report_mismatch("source_value", rsp_source_value, e.sv);
               if (rsp_flags_out !== e.fl) report_mismatch("flags", rsp_flags_out, e.fl);
               if (rsp_remainder_out !== e.rem)
                  report_mismatch("remainder", rsp_remainder_out, e.rem);
               if (rsp_branch_taken !== e.br)
                  report_mismatch("branch_taken", rsp_branch_taken, e.br);
               if (rsp_status !== e.st) report_mismatch("status", rsp_status, e.st);
            end
         end
      end
      pending_count <= exec_queue.size();
   end
endmodule

// File: dv/vm_alu_condition_branch_top_test.sv
module vm_alu_condition_branch_top_test;
   import vmalu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   logic req_valid, req_ready;
   logic [4:0] req_func;
   logic signed [31:0] req_a_value, req_b_value;
   logic rsp_valid, rsp_ready;
   logic rsp_write_dest, rsp_write_source, rsp_branch_taken;
   logic signed [31:0] rsp_dest_value, rsp_source_value, rsp_remainder_out;
   logic [1:0] rsp_flags_out, rsp_status;
   int unsigned fail_count, pending_count, word_count;
   int unsigned cycle_count;
   int unsigned sent_count;

   vm_alu_condition_branch_top DUT (.*);

   vm_alu_condition_branch_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous limit: division words are the slowest, plus long gaps on both sides.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // Random gap length: mostly short, a few long.
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Operand with a bias toward the corner values.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0;
         4: return $urandom_range(0, 40);
         5: return -$urandom_range(1, 40);
         default: return $urandom;
      endcase
   endfunction

   // Offer one word at the falling edge and hold it until accepted.
   task automatic send_word(logic [4:0] f, logic [31:0] a, logic [31:0] b);
      int unsigned g;
      g = gap_len();
      repeat (g) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= f;
      req_a_value <= a;
      req_b_value <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
   initial begin
      int unsigned g;
      logic held;
      held = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && sent_count >= 600) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
         end else begin
            g = gap_len();
            if (g > 0) begin
               rsp_ready <= 1'b0;
               repeat (g) @(negedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   initial begin
      logic [4:0] f;
      int unsigned n;
      int unsigned waited;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = '0;
      req_a_value = '0;
      req_b_value = '0;
      sent_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: jumps on reset flags, most opcodes, the special cases.
      for (int j = OP_JMP; j <= OP_JNN; j++) send_word(5'(j), 0, 0);
      send_word(OP_ADD, 32'h7FFF_FFFF, 1);          // overflow wraps
      send_word(OP_SUB, 32'h8000_0000, 1);
      send_word(OP_MUL, 32'h4000_0000, 4);          // product wraps to zero
      send_word(OP_DIV, 32'h8000_0000, -1);         // most negative over minus one
      send_word(OP_DIV, -7, 2);                     // truncation, remainder sign
      send_word(OP_DIV, 7, -2);
      send_word(OP_DIV, 5, 0);                      // zero divisor
      send_word(OP_CMP, 3, 3);
      send_word(OP_JZ, 0, 0);
      send_word(OP_NOT, 0, 0);
      send_word(OP_JN, 0, 0);
      send_word(OP_SHL, 32'hFFFF_FFFF, 32);         // large shift amounts
      send_word(OP_SHR, 32'hFFFF_FFFF, 32'h8000_0000);
      send_word(OP_SAR, 32'h8000_0000, 40);
      send_word(OP_SAR, 32'h8000_0000, 31);
      send_word(OP_SWAP, 32'h1234_5678, 32'h9ABC_DEF0);
      send_word(OP_LDL, 32'hFFFF_FFFF, 32'h0000_1234);
      send_word(OP_LDH, 32'h0, 32'hABCD_FFFF);
      send_word(5'd0, 1, 1);                        // unhandled opcodes
      send_word(5'd31, 1, 1);
      send_word(OP_MOV, 0, 32'h7FFF_FFFF);

      // Random mix; the receiver holds off once in the middle.
      for (n = 0; n < 1630; n++) begin
         case ($urandom_range(0, 9))
            0, 1: f = 5'($urandom_range(OP_JMP, OP_JNN));
            2: f = OP_DIV;
            3: f = 5'($urandom_range(0, 31));
            default: f = 5'($urandom_range(OP_NOT, OP_LDH));
         endcase
         if (f == 5'd9) f = OP_NOT;
         send_word(f, pick_value(), ($urandom_range(0, 3) == 0) ?
                   32'($urandom_range(0, 40)) : pick_value());
      end
      @(negedge clock);
      req_valid <= 1'b0;

      waited = 0;
      while ((pending_count != 0 || word_count != sent_count) && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      $display("sent %0d words, checked %0d results", sent_count, word_count);
      $display("covered all opcodes, division corners, shift limits and a full stall");
      if (fail_count == 0 && pending_count == 0 && word_count == sent_count) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
